[src/assert_macros.svh]
// assertion helpers shared by the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define CTC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ctc assertion failed");

// clocked property, checked during reset as well
`define CTC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ctc assertion failed");

`endif

[src/ctc_pkg.sv]
package ctc_pkg;

   localparam int MAX_CHANNELS = 4;
   localparam int COUNT_WIDTH  = 9;

   localparam int          ENABLE_BIT    = 7;
   localparam int          AWAIT_BIT     = 2;
   localparam int          RESET_BIT     = 1;
   localparam int          CONTROL_BIT   = 0;
   localparam logic [7:0]  VECTOR_MASK   = 8'hF8;
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = 9'd256;
   localparam logic [7:0]  DISABLED_READ = 8'hFF;
   localparam logic [1:0]  TICK_CHANNEL  = 2'd3;
   localparam logic [1:0]  DISK_CHANNEL0 = 2'd0;
   localparam logic [1:0]  DISK_CHANNEL1 = 2'd1;
   localparam logic [1:0]  VECTOR_CHANNEL = 2'd0;
   localparam logic        REG_BOARD_ENABLED = 1'b0;

   typedef enum logic [2:0] {
      OP_WRITE      = 3'd0,
      OP_READ       = 3'd1,
      OP_EVENT      = 3'd2,
      OP_POLL       = 3'd3,
      OP_RETURN     = 3'd4,
      OP_CLEAR_DISK = 3'd5
   } opcode_type;

   typedef struct packed {
      logic       clear_all;
      logic       write;
      logic       count_event;
      logic       clear_pending;
      logic       grant;
      logic       unserve;
      logic [7:0] data;
   } chan_cmd_type;

   typedef struct packed {
      logic       pending;
      logic       in_service;
      logic       awaiting;
      logic [7:0] count_low;
   } chan_status_type;

endpackage

[src/ctc_event_counter_interrupt_chain.sv]
// event counter with a four-level vectored interrupt chain
// request channel (req_*): one operation per transfer, write, read count, event,
//   acknowledge poll (with an optional event on channel 3 first), return from
//   interrupt, or clear of pending interrupts on channels 0 and 1
// response channel (rsp_*): exactly one transfer per request, carrying the read
//   byte and, for a poll, the grant flag and vector
// a request taken at an edge shows its response from that edge on; throughput is
//   one request per cycle while the receiver keeps up, set by the single output
//   register, whose slot frees in the same cycle the receiver takes it
// when the receiver stalls the response holds and req_ready drops until the
//   response is taken
// csr port: register 0 at address 0 is board_enabled; a write that changes it
//   clears every channel and the vector base; while it is low writes, events
//   and polls do nothing and reads return 255
// reset clears all channel state, the board enable and the response slot
`include "assert_macros.svh"

module ctc_event_counter_interrupt_chain #(
   parameter int NUM_CHANNELS = ctc_pkg::MAX_CHANNELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_data,
   input  logic        req_cpu_int_enabled,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_int_valid,
   output logic [7:0]  rsp_int_vector,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ctc_pkg::*;

   logic            board_enabled_ff;
   logic [7:0]      vector_base_ff, vector_base_in;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_read_data_ff, rsp_read_data_in;
   logic            rsp_int_valid_ff, rsp_int_valid_in;
   logic [7:0]      rsp_int_vector_ff, rsp_int_vector_in;

   logic            accept, csr_write, clear_all, active;
   logic            poll_live, return_live;
   opcode_type      op;
   chan_cmd_type    chan_cmd [NUM_CHANNELS];
   chan_status_type chan_status [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] grant, unserve;

   assign op        = opcode_type'(req_opcode);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == REG_BOARD_ENABLED);
   assign clear_all = csr_write && (csr_pwdata[0] != board_enabled_ff);
   assign active    = accept && board_enabled_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BOARD_ENABLED) ?
                       {31'd0, board_enabled_ff} : 32'd0;

   assign poll_live   = active && (op == OP_POLL) && req_cpu_int_enabled;
   assign return_live = accept && (op == OP_RETURN);

   // daisy chain: an in-service channel blocks itself and everything below; a pending one blocks everything below
   always_comb begin
      logic blocked;
      logic found;
      blocked           = 1'b0;
      found             = 1'b0;
      grant             = '0;
      unserve           = '0;
      rsp_int_valid_in  = 1'b0;
      rsp_int_vector_in = 8'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!blocked) begin
            if (chan_status[i].in_service) begin
               blocked = 1'b1;
            end else if (chan_status[i].pending) begin
               blocked = 1'b1;
               if (poll_live) begin
                  grant[i]          = 1'b1;
                  rsp_int_valid_in  = 1'b1;
                  rsp_int_vector_in = vector_base_ff + 8'(2 * i);
               end
            end
         end
         if (!found && chan_status[i].in_service) begin
            found = 1'b1;
            unserve[i] = return_live;
         end
      end
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      always_comb begin
         chan_cmd[g].clear_all     = clear_all;
         chan_cmd[g].write         = active && (op == OP_WRITE) && (req_channel == 2'(g));
         chan_cmd[g].count_event   = active &&
            (((op == OP_EVENT) && (req_channel == 2'(g))) ||
             ((op == OP_POLL) && req_tick && (TICK_CHANNEL == 2'(g))));
         chan_cmd[g].clear_pending = active && (op == OP_CLEAR_DISK) &&
            ((DISK_CHANNEL0 == 2'(g)) || (DISK_CHANNEL1 == 2'(g)));
         chan_cmd[g].grant         = grant[g];
         chan_cmd[g].unserve       = unserve[g];
         chan_cmd[g].data          = req_data;
      end

      ctc_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .cmd    (chan_cmd[g]),
         .status (chan_status[g])
      );
   end

   // even byte on channel 0 with no constant awaited sets the vector base
   always_comb begin
      vector_base_in = vector_base_ff;
      if (active && (op == OP_WRITE) && (req_channel == VECTOR_CHANNEL) &&
          !chan_status[0].awaiting && !req_data[CONTROL_BIT]) begin
         vector_base_in = req_data & VECTOR_MASK;
      end
      if (clear_all) vector_base_in = 8'd0;
   end

   always_comb begin
      rsp_read_data_in = 8'd0;
      if (op == OP_READ) begin
         rsp_read_data_in = DISABLED_READ;
         if (board_enabled_ff) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (req_channel == 2'(i)) rsp_read_data_in = chan_status[i].count_low;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_enabled_ff <= 1'b0;
         vector_base_ff   <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) board_enabled_ff <= csr_pwdata[0];
         vector_base_ff <= vector_base_in;
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_data_ff  <= rsp_read_data_in;
         rsp_int_valid_ff  <= rsp_int_valid_in;
         rsp_int_vector_ff <= rsp_int_vector_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_int_valid  = rsp_int_valid_ff;
   assign rsp_int_vector = rsp_int_vector_ff;

   `CTC_ASSERT(a_accept_fills_slot, clock, reset, accept |=> rsp_valid_ff)
   `CTC_ASSERT(a_grant_only_on_poll, clock, reset,
      (accept && ((op != OP_POLL) || !req_cpu_int_enabled)) |=> !rsp_int_valid_ff)
   `CTC_ASSERT(a_disabled_read, clock, reset,
      (accept && (op == OP_READ) && !board_enabled_ff) |=>
         (rsp_read_data_ff == DISABLED_READ))
   `CTC_ASSERT_ALWAYS(a_grant_onehot, clock, $onehot0(grant))

endmodule

[src/ctc_channel.sv]
module ctc_channel (
   input  logic                     clock,
   input  logic                     reset,
   input  ctc_pkg::chan_cmd_type    cmd,
   output ctc_pkg::chan_status_type status
);
   import ctc_pkg::*;

   logic                   enable_ff, enable_in, enable_mid;
   logic                   await_ff, await_in, await_mid;
   logic                   pending_ff, pending_in, pending_mid;
   logic                   service_ff, service_in, service_mid;
   logic [COUNT_WIDTH-1:0] reload_ff, reload_in, reload_mid;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_mid;
   logic [COUNT_WIDTH-1:0] load_value;

   assign load_value = (cmd.data == 8'd0) ? FULL_COUNT : {1'b0, cmd.data};

   // port write, event and disk clear
   always_comb begin
      enable_mid  = enable_ff;
      await_mid   = await_ff;
      pending_mid = pending_ff;
      service_mid = service_ff;
      reload_mid  = reload_ff;
      count_mid   = count_ff;
      if (cmd.write) begin
         if (await_ff) begin
            reload_mid = load_value;
            count_mid  = load_value;
            await_mid  = 1'b0;
         end else if (cmd.data[CONTROL_BIT]) begin
            enable_mid = cmd.data[ENABLE_BIT];
            if (cmd.data[RESET_BIT]) begin
               pending_mid = 1'b0;
               service_mid = 1'b0;
               count_mid   = '0;
            end
            await_mid = cmd.data[AWAIT_BIT];
            if (!cmd.data[ENABLE_BIT]) pending_mid = 1'b0;
         end
      end
      if (cmd.count_event && enable_ff && !await_ff && count_ff != '0) begin
         if (count_ff == COUNT_WIDTH'(1)) begin
            count_mid   = reload_ff;
            pending_mid = 1'b1;
         end else begin
            count_mid = count_ff - COUNT_WIDTH'(1);
         end
      end
      if (cmd.clear_pending) pending_mid = 1'b0;
   end

   // acknowledge and return from interrupt act after the event
   always_comb begin
      enable_in  = enable_mid;
      await_in   = await_mid;
      pending_in = pending_mid;
      service_in = service_mid;
      reload_in  = reload_mid;
      count_in   = count_mid;
      if (cmd.grant) begin
         pending_in = 1'b0;
         service_in = 1'b1;
      end
      if (cmd.unserve) service_in = 1'b0;
      if (cmd.clear_all) begin
         enable_in  = 1'b0;
         await_in   = 1'b0;
         pending_in = 1'b0;
         service_in = 1'b0;
         reload_in  = '0;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         await_ff   <= 1'b0;
         pending_ff <= 1'b0;
         service_ff <= 1'b0;
         reload_ff  <= '0;
         count_ff   <= '0;
      end else begin
         enable_ff  <= enable_in;
         await_ff   <= await_in;
         pending_ff <= pending_in;
         service_ff <= service_in;
         reload_ff  <= reload_in;
         count_ff   <= count_in;
      end
   end

   assign status.pending    = pending_mid;
   assign status.in_service = service_ff;
   assign status.awaiting   = await_ff;
   assign status.count_low  = count_ff[7:0];

endmodule

[tb/ctc_event_counter_interrupt_chain_tb.sv]
`timescale 1ns / 1ps

module ctc_event_counter_interrupt_chain_tb;
   import ctc_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam logic [2:0] BOARD_ENABLED_ADDR = 3'(4 * int'(REG_BOARD_ENABLED));
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int LONG_HOLD   = 40;

   typedef struct packed {
      logic [7:0] read_data;
      logic       int_valid;
      logic [7:0] int_vector;
   } bus_outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [1:0]  req_channel;
   logic [7:0]  req_data;
   logic        req_cpu_int_enabled;
   logic        req_tick;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_data;
   logic        rsp_int_valid;
   logic [7:0]  rsp_int_vector;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the block's state
   logic                   board_on;
   logic [7:0]             chan_ctrl   [MAX_CHANNELS];
   logic [COUNT_WIDTH-1:0] chan_reload [MAX_CHANNELS];
   logic [COUNT_WIDTH-1:0] chan_count  [MAX_CHANNELS];
   logic                   chan_await  [MAX_CHANNELS];
   logic                   chan_pend   [MAX_CHANNELS];
   logic                   chan_serv   [MAX_CHANNELS];
   logic [7:0]             vector_base;

   bus_outcome_type outcomes_due[$];
   int  fail_count = 0;
   int  ops_sent = 0;
   int  outcomes_checked = 0;
   int  grants_seen = 0;
   int  csr_writes = 0;
   int  cycle_count = 0;
   bit  src_gaps = 1'b0;
   bit  sink_stalls = 1'b0;
   int  sink_hold_cycles = 0;

   ctc_event_counter_interrupt_chain #(
      .NUM_CHANNELS(MAX_CHANNELS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_channel(req_channel),
      .req_data(req_data),
      .req_cpu_int_enabled(req_cpu_int_enabled),
      .req_tick(req_tick),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_int_valid(rsp_int_valid),
      .rsp_int_vector(rsp_int_vector),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** ctc_event_counter_interrupt_chain: FAILED **");
         $finish;
      end
   end

   function automatic void clear_channel_state();
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         chan_ctrl[i]   = '0;
         chan_reload[i] = '0;
         chan_count[i]  = '0;
         chan_await[i]  = 1'b0;
         chan_pend[i]   = 1'b0;
         chan_serv[i]   = 1'b0;
      end
      vector_base = '0;
   endfunction

   function automatic void count_channel_event(input int ch);
      if (!chan_ctrl[ch][ENABLE_BIT] || chan_await[ch] || chan_count[ch] == '0) return;
      chan_count[ch] = chan_count[ch] - 1'b1;
      if (chan_count[ch] == '0) begin
         chan_count[ch] = chan_reload[ch];
         chan_pend[ch]  = 1'b1;
      end
   endfunction

   function automatic void apply_port_write(input int ch, input logic [7:0] value);
      if (chan_await[ch]) begin
         chan_reload[ch] = (value == 8'd0) ? FULL_COUNT : {1'b0, value};
         chan_count[ch]  = chan_reload[ch];
         chan_await[ch]  = 1'b0;
      end else if (value[CONTROL_BIT]) begin
         chan_ctrl[ch] = value;
         if (value[RESET_BIT]) begin
            chan_pend[ch]  = 1'b0;
            chan_serv[ch]  = 1'b0;
            chan_count[ch] = '0;
         end
         chan_await[ch] = value[AWAIT_BIT];
         if (!value[ENABLE_BIT]) chan_pend[ch] = 1'b0;
      end else if (ch == int'(VECTOR_CHANNEL)) begin
         vector_base = value & VECTOR_MASK;
      end
   endfunction

   function automatic bus_outcome_type bus_cycle_outcome(input logic [2:0] op,
                                                         input logic [1:0] ch,
                                                         input logic [7:0] value,
                                                         input logic cpu_on,
                                                         input logic tick_on);
      bus_outcome_type o;
      logic            done;
      o = '0;
      done = 1'b0;
      case (op)
         OP_WRITE: begin
            if (board_on) apply_port_write(int'(ch), value);
         end
         OP_READ: begin
            o.read_data = board_on ? chan_count[ch][7:0] : DISABLED_READ;
         end
         OP_EVENT: begin
            if (board_on) count_channel_event(int'(ch));
         end
         OP_POLL: begin
            if (board_on) begin
               if (tick_on) count_channel_event(int'(TICK_CHANNEL));
               if (cpu_on) begin
                  // daisy chain: a channel in service blocks itself and all below; a pending one blocks all below
                  for (int i = 0; i < MAX_CHANNELS; i++) begin
                     if (!done) begin
                        if (chan_serv[i]) begin
                           done = 1'b1;
                        end else if (chan_pend[i]) begin
                           chan_pend[i] = 1'b0;
                           chan_serv[i] = 1'b1;
                           o.int_valid  = 1'b1;
                           o.int_vector = vector_base + 8'(2 * i);
                           done = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         OP_RETURN: begin
            // acts even with the board disabled
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               if (!done && chan_serv[i]) begin
                  chan_serv[i] = 1'b0;
                  done = 1'b1;
               end
            end
         end
         OP_CLEAR_DISK: begin
            if (board_on) begin
               chan_pend[DISK_CHANNEL0] = 1'b0;
               chan_pend[DISK_CHANNEL1] = 1'b0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // response side: random short stalls, or one long hold when asked
   initial begin : response_sink
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : response_check
      bus_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcomes_due.size() == 0) begin
            $error("response transfer with nothing outstanding");
            fail_count++;
         end else begin
            want = outcomes_due.pop_front();
            outcomes_checked++;
            if (rsp_int_valid) grants_seen++;
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %0d, got %0d", want.read_data, rsp_read_data);
               fail_count++;
            end
            if (rsp_int_valid !== want.int_valid) begin
               $error("int_valid: expected %0d, got %0d", want.int_valid, rsp_int_valid);
               fail_count++;
            end
            if (rsp_int_vector !== want.int_vector) begin
               $error("int_vector: expected 0x%02h, got 0x%02h",
                      want.int_vector, rsp_int_vector);
               fail_count++;
            end
         end
      end
   end

   task automatic send_op(input logic [2:0] op, input logic [1:0] ch,
                          input logic [7:0] value, input logic cpu_on,
                          input logic tick_on);
      bus_outcome_type want;
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_channel         <= ch;
      req_data            <= value;
      req_cpu_int_enabled <= cpu_on;
      req_tick            <= tick_on;
      do @(posedge clock); while (!(req_valid && req_ready));
      want = bus_cycle_outcome(op, ch, value, cpu_on, tick_on);
      outcomes_due.push_back(want);
      ops_sent++;
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic await_all_outcomes();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (outcomes_due.size() != 0) begin
         $error("%0d responses never arrived", outcomes_due.size());
         fail_count++;
         outcomes_due.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_board_enable(input logic enable);
      await_all_outcomes();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BOARD_ENABLED_ADDR;
      csr_pwdata  <= {$urandom() & 32'hFFFF_FFFE} | 32'(enable);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (enable != board_on) begin
         board_on = enable;
         clear_channel_state();
      end
      csr_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      // read back
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(board_on)) begin
         $error("board_enabled: expected %0d, got %0d", board_on, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_op();
      int         pick;
      logic [1:0] ch;
      logic [7:0] value;
      pick = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      if (pick < 10) begin
         // channel setup: control word awaiting a constant, then the constant
         value = 8'($urandom()) | 8'h05;
         if ($urandom_range(0, 4) != 0) value[ENABLE_BIT] = 1'b1;
         if ($urandom_range(0, 2) != 0) value[RESET_BIT] = 1'b0;
         send_op(OP_WRITE, ch, value, 1'($urandom()), 1'($urandom()));
         if ($urandom_range(0, 7) == 0) value = 8'($urandom());
         else value = 8'($urandom_range(1, 4));
         send_op(OP_WRITE, ch, value, 1'($urandom()), 1'($urandom()));
      end else if (pick < 45) begin
         send_op(OP_EVENT, ch, 8'($urandom()), 1'($urandom()), 1'($urandom()));
      end else if (pick < 65) begin
         send_op(OP_POLL, ch, 8'($urandom()), 1'($urandom_range(0, 4) != 0),
                 1'($urandom()));
      end else if (pick < 75) begin
         send_op(OP_RETURN, ch, 8'($urandom()), 1'($urandom()), 1'($urandom()));
      end else if (pick < 83) begin
         send_op(OP_READ, ch, 8'($urandom()), 1'($urandom()), 1'($urandom()));
      end else if (pick < 86) begin
         send_op(OP_CLEAR_DISK, ch, 8'($urandom()), 1'($urandom()), 1'($urandom()));
      end else if (pick < 89) begin
         send_op(OP_WRITE, VECTOR_CHANNEL, 8'($urandom()) & 8'hFE, 1'($urandom()),
                 1'($urandom()));
      end else begin
         send_op(3'($urandom_range(0, 7)), ch, 8'($urandom()), 1'($urandom()),
                 1'($urandom()));
      end
   endtask

   task automatic test_board_disabled();
      write_board_enable(1'b0);   // same value, nothing changes
      send_op(OP_READ, 2'd2, 8'h00, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd0, 8'h85, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd0, 8'h01, 1'b0, 1'b0);
      send_op(OP_EVENT, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_POLL, 2'd0, 8'h00, 1'b1, 1'b1);
      send_op(OP_CLEAR_DISK, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_RETURN, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_READ, 2'd0, 8'hFF, 1'b1, 1'b1);
      await_all_outcomes();
   endtask

   task automatic test_channel_basics();
      write_board_enable(1'b1);
      send_op(OP_WRITE, 2'd0, 8'hFF, 1'b0, 1'b0);   // enable, reset, await constant
      send_op(OP_WRITE, 2'd0, 8'h02, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd0, 8'hFE, 1'b0, 1'b0);   // vector base
      send_op(OP_WRITE, 2'd1, 8'h80, 1'b0, 1'b0);   // even byte off channel 0: ignored
      send_op(OP_EVENT, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_READ, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_EVENT, 2'd0, 8'h00, 1'b0, 1'b0);   // expires, reloads
      send_op(OP_POLL, 2'd0, 8'h00, 1'b0, 1'b0);    // interrupts off: no grant
      send_op(OP_POLL, 2'd0, 8'h00, 1'b1, 1'b0);
      send_op(OP_WRITE, 2'd3, 8'h85, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd3, 8'h00, 1'b0, 1'b0);   // zero loads a full count
      send_op(OP_READ, 2'd3, 8'h00, 1'b0, 1'b0);
      send_op(OP_POLL, 2'd3, 8'h00, 1'b1, 1'b1);    // tick on channel 3, chain blocked
      send_op(OP_WRITE, 2'd2, 8'h85, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd2, 8'h01, 1'b0, 1'b0);
      send_op(OP_EVENT, 2'd2, 8'h00, 1'b0, 1'b0);
      send_op(OP_POLL, 2'd0, 8'h00, 1'b1, 1'b0);    // channel 0 in service blocks 2
      send_op(OP_RETURN, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_POLL, 2'd0, 8'h00, 1'b1, 1'b0);
      send_op(OP_RETURN, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd1, 8'h85, 1'b0, 1'b0);
      send_op(OP_WRITE, 2'd1, 8'h01, 1'b0, 1'b0);
      send_op(OP_EVENT, 2'd1, 8'h00, 1'b0, 1'b0);
      send_op(OP_CLEAR_DISK, 2'd1, 8'h00, 1'b0, 1'b0);
      send_op(OP_POLL, 2'd1, 8'h00, 1'b1, 1'b0);
      send_op(OP_WRITE, 2'd1, 8'h05, 1'b0, 1'b0);   // control without enable
      send_op(OP_WRITE, 2'd1, 8'hFF, 1'b0, 1'b0);
      send_op(OP_SPARE_6, 2'd3, 8'hFF, 1'b1, 1'b1);
      send_op(OP_SPARE_7, 2'd0, 8'h00, 1'b1, 1'b1);
      send_op(OP_WRITE, 2'd0, 8'h03, 1'b0, 1'b0);   // channel reset clears the count
      send_op(OP_EVENT, 2'd0, 8'h00, 1'b0, 1'b0);
      send_op(OP_READ, 2'd0, 8'h00, 1'b0, 1'b0);
      await_all_outcomes();
   endtask

   task automatic test_random_traffic(input int count, input bit with_idling);
      int stop_at;
      stop_at = ops_sent + count;
      while (ops_sent < stop_at) begin
         // alternate stretches with and without idling
         src_gaps    = with_idling && ((ops_sent / 50) % 2 == 0);
         sink_stalls = with_idling && ((ops_sent / 70) % 2 == 0);
         send_random_op();
      end
      await_all_outcomes();
   endtask

   task automatic test_output_backpressure();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      sink_hold_cycles = LONG_HOLD;
      // sender keeps offering while responses are held off
      for (int i = 0; i < 12; i++) send_random_op();
      await_all_outcomes();
   endtask

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_opcode          <= OP_READ;
      req_channel         <= 2'd0;
      req_data            <= 8'h00;
      req_cpu_int_enabled <= 1'b0;
      req_tick            <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= BOARD_ENABLED_ADDR;
      csr_pwdata          <= '0;
      board_on = 1'b0;
      clear_channel_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_board_disabled();
      test_channel_basics();
      test_random_traffic(220, 1'b1);
      write_board_enable(1'b0);
      test_random_traffic(60, 1'b1);
      write_board_enable(1'b1);
      test_random_traffic(200, 1'b1);
      write_board_enable(1'b1);   // unchanged value keeps channel state
      test_output_backpressure();
      write_board_enable(1'b0);
      write_board_enable(1'b1);
      test_random_traffic(120, 1'b0);
      await_all_outcomes();

      $display("ran %0d bus operations, %0d responses checked, %0d interrupts granted",
               ops_sent, outcomes_checked, grants_seen);
      $display("%0d board enable writes, disabled and enabled phases, long output hold",
               csr_writes);
      if (fail_count == 0) begin
         $display("** ctc_event_counter_interrupt_chain: PASSED **");
      end else begin
         $display("** ctc_event_counter_interrupt_chain: FAILED **");
      end
      $finish;
   end

endmodule
